// ===== rtl/brfr_pkg.sv =====
// package: sizes and operation codes of the byte ring fifo with rewind
`default_nettype none
package brfr_pkg;

  localparam int DEPTH = 256;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;
  localparam int DW    = 8;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_REWIND = 2'd3
  } mode_t;

endpackage
`default_nettype wire

// ===== rtl/brfr_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none
module brfr_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/byte_ring_fifo_with_rewind_unit.sv =====
// top level: circular byte fifo with write, read, clear and rewind operations
//
// usage:
//   an item (mode, data_in, rewind_amount, last_in) is taken at a rising edge
//   where start is high and busy is low. busy stays low, so an item can be
//   given every cycle.
//   mode: write stores data_in unless full; read returns the byte at the read
//   index unless empty; clear empties the fifo and its read history; rewind
//   moves the read index back, capped by the bytes read since the last clear
//   and not yet overwritten.
//   each item gives one result, shown for exactly one cycle with done high,
//   in the cycle after the item was taken. throughput is one item per cycle,
//   set by the registered read of the byte ram and the pointer update.
//   the receiver cannot stall; results must be taken when done is high.
//   reset (rst, synchronous) zeroes the indices, the fill count and the read
//   history; the byte ram is not cleared and needs no clearing pass, since
//   no byte is readable before it is written.
//   read_position, fill_level and free_space give the state after the item.
`default_nettype none
module byte_ring_fifo_with_rewind_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   mode,
  input  wire logic [brfr_pkg::DW-1:0]      data_in,
  input  wire logic [brfr_pkg::CW-1:0]      rewind_amount,
  input  wire logic                         last_in,
  output logic                              done,
  output logic      [brfr_pkg::DW-1:0]      read_byte,
  output logic                              accepted,
  output logic      [brfr_pkg::CW-1:0]      applied_amount,
  output logic      [brfr_pkg::AW-1:0]      read_position,
  output logic      [brfr_pkg::CW-1:0]      fill_level,
  output logic      [brfr_pkg::CW-1:0]      free_space,
  output logic                              last_out
);

  logic                     accept;
  logic [brfr_pkg::AW-1:0]  read_index;
  logic [brfr_pkg::AW-1:0]  read_index_next;
  logic [brfr_pkg::AW-1:0]  write_index;
  logic [brfr_pkg::AW-1:0]  write_index_next;
  logic [brfr_pkg::CW-1:0]  fill_count;
  logic [brfr_pkg::CW-1:0]  fill_count_next;
  logic [brfr_pkg::CW-1:0]  consumed;
  logic [brfr_pkg::CW-1:0]  consumed_next;
  logic [brfr_pkg::CW-1:0]  free_now;
  logic [brfr_pkg::CW-1:0]  free_after_write;
  logic [brfr_pkg::CW-1:0]  cap;
  logic [brfr_pkg::CW-1:0]  applied;
  logic [brfr_pkg::CW-1:0]  applied_cand;
  logic                     ok;
  logic                     rd_hit;
  logic                     rd_hit_q;
  logic                     we;
  logic [brfr_pkg::DW-1:0]  rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    read_index_next  = read_index;
    write_index_next = write_index;
    fill_count_next  = fill_count;
    consumed_next    = consumed;
    ok               = 1'b0;
    rd_hit           = 1'b0;
    we               = 1'b0;
    applied          = '0;
    free_now         = brfr_pkg::DEPTH_C - fill_count;
    free_after_write = free_now - brfr_pkg::CW'(1);
    cap              = (consumed < free_now) ? consumed : free_now;
    applied_cand     = (rewind_amount < cap) ? rewind_amount : cap;
    case (mode)
      brfr_pkg::MODE_WRITE: begin
        if (fill_count != brfr_pkg::DEPTH_C) begin
          we               = accept;
          write_index_next = write_index + brfr_pkg::AW'(1);
          fill_count_next  = fill_count + brfr_pkg::CW'(1);
          consumed_next    = (consumed < free_after_write) ? consumed : free_after_write;
          ok               = 1'b1;
        end
      end
      brfr_pkg::MODE_READ: begin
        if (fill_count != '0) begin
          rd_hit          = 1'b1;
          read_index_next = read_index + brfr_pkg::AW'(1);
          fill_count_next = fill_count - brfr_pkg::CW'(1);
          if (consumed != brfr_pkg::DEPTH_C) begin
            consumed_next = consumed + brfr_pkg::CW'(1);
          end
          ok = 1'b1;
        end
      end
      brfr_pkg::MODE_CLEAR: begin
        read_index_next  = '0;
        write_index_next = '0;
        fill_count_next  = '0;
        consumed_next    = '0;
        ok               = 1'b1;
      end
      brfr_pkg::MODE_REWIND: begin
        applied         = applied_cand;
        read_index_next = read_index - applied[brfr_pkg::AW-1:0];
        fill_count_next = fill_count + applied;
        consumed_next   = consumed - applied;
        ok              = (applied == rewind_amount);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  brfr_ram #(
    .AW (brfr_pkg::AW),
    .DW (brfr_pkg::DW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (write_index),
    .wdata (data_in),
    .raddr (read_index),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      read_index  <= '0;
      write_index <= '0;
      fill_count  <= '0;
      consumed    <= '0;
      done        <= 1'b0;
      rd_hit_q    <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        read_index  <= read_index_next;
        write_index <= write_index_next;
        fill_count  <= fill_count_next;
        consumed    <= consumed_next;
        rd_hit_q    <= rd_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      accepted       <= ok;
      applied_amount <= applied;
      last_out       <= last_in;
    end
  end

  assign read_byte     = rd_hit_q ? rdata : '0;
  assign read_position = read_index;
  assign fill_level    = fill_count;
  assign free_space    = brfr_pkg::DEPTH_C - fill_count;

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= brfr_pkg::DEPTH_C)
    else $error("fill count beyond depth");

  a_history_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, consumed} + {1'b0, fill_count}) <= {1'b0, brfr_pkg::DEPTH_C})
    else $error("read history overlaps unread or overwritten bytes");

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("item without result");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == brfr_pkg::MODE_WRITE || mode == brfr_pkg::MODE_READ)) |=>
    (fill_count == $past(fill_count) + brfr_pkg::CW'(1)
     || fill_count == $past(fill_count) - brfr_pkg::CW'(1)
     || fill_count == $past(fill_count)))
    else $error("fill count moved by more than one on write or read");

  a_rewind_applied: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(rst) && $past(mode) == brfr_pkg::MODE_REWIND) |->
    (applied_amount <= $past(rewind_amount)))
    else $error("rewind applied more than asked");
`endif

endmodule
`default_nettype wire
